// ----- rtl/smfb_pkg.sv -----
package smfb_pkg;

  localparam int MAX_LEN   = 64;
  localparam int MAX_BATCH = 16;
  localparam int LEN_W     = 7;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int COL_W     = 4;
  localparam int CACHE_AW  = COL_W + IDX_W;
  localparam int E_W       = 17;
  localparam int SUM_W     = 23;
  localparam int NUM_W     = 34;
  localparam int Q_W       = 18;
  localparam int DOT_W     = 40;
  localparam int OUT_W     = 17;

  localparam logic REG_VLEN  = 1'b0;
  localparam logic REG_BATCH = 1'b1;

  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_BWD = 1'b1;

  typedef enum logic [4:0] {
    S_LOAD, S_CHECK,
    S_F1_RD, S_F1_EXP, S_F1_WAIT,
    S_F2_RD, S_F2_DIV, S_F2_WAIT,
    S_D1_RD, S_D1_MUL, S_D1_ACC,
    S_D2_RD, S_D2_DIFF, S_D2_MLO, S_D2_MHI, S_D2_SUM, S_D2_FIN,
    S_EMIT
  } state_t;

  // c_k = exp(-2^k/256) in Q0.32, each square rounded half up.
  function automatic logic [31:0] exp_step(input int k);
    logic [63:0] c;
    c = 64'hFF007FD5;
    for (int i = 0; i < k; i++) begin
      c = (c * c + 64'h8000_0000) >> 32;
    end
    return c[31:0];
  endfunction

  localparam logic [31:0] EXP_C [16] = '{
    exp_step(0),  exp_step(1),  exp_step(2),  exp_step(3),
    exp_step(4),  exp_step(5),  exp_step(6),  exp_step(7),
    exp_step(8),  exp_step(9),  exp_step(10), exp_step(11),
    exp_step(12), exp_step(13), exp_step(14), exp_step(15)
  };

endpackage

// ----- rtl/smfb_ram.sv -----
module smfb_ram #(
  parameter int AW = 6,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/smfb_exp.sv -----
module smfb_exp
  import smfb_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [15:0]    t,
  output logic           done,
  output logic [E_W-1:0] e
);

  logic [15:0] t_r;
  logic [32:0] r_r;
  logic [3:0]  k_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] prod;
  logic [64:0] prod_rnd;
  logic [32:0] r_rnd;

  assign prod     = r_r * {33'd0, EXP_C[k_r]};
  assign prod_rnd = prod + 65'h0_8000_0000;
  assign r_rnd    = r_r + 33'h8000;
  assign e        = r_rnd[32:16];
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
        t_r    <= t;
        r_r    <= 33'h1_0000_0000;
      end else if (busy_r) begin
        if (t_r[k_r]) begin
          r_r <= prod_rnd[64:32];
        end
        k_r <= k_r + 4'd1;
        if (k_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/smfb_div.sv -----
module smfb_div
  import smfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  logic [NUM_W-1:0] num_r;
  logic [SUM_W-1:0] den_r;
  logic [SUM_W:0]   rem_r;
  logic [Q_W-1:0]   q_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SUM_W:0]   trial;
  logic             fits;

  assign trial = {rem_r[SUM_W-1:0], num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= 6'(NUM_W);
      end else if (busy_r) begin
        rem_r <= fits ? trial - {1'b0, den_r} : trial;
        q_r   <= {q_r[Q_W-2:0], fits};
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/softmax_forward_backward_core.sv -----
// Softmax with gradient over column vectors of up to 64 elements.
// Elements are accepted while the core is loading; a vector is processed after its last element.
// Forward: exp of each element (16-step multiply loop), then per element the 34-step
// serial divide and emission. Backward: a dot-product pass, then a gradient pass.
// One vector is handled at a time; the input stalls while results are produced.
// Reset (synchronous, active low) restores the sequencer, configuration and vector state; memories are not cleared.
module softmax_forward_backward_core
  import smfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] column, [19:4] in_value, [23:20] zero
  input  logic        in_tuser,   // cmd
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] out_value, [23:17] zero
  output logic        out_tuser,  // error
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic [LEN_W-1:0] vlen_r;
  logic [4:0]       batch_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_BATCH) ? {27'd0, batch_r} : {25'd0, vlen_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r  <= 7'd64;
      batch_r <= 5'd16;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_VLEN) begin
        vlen_r <= cfg_pwdata[LEN_W-1:0];
      end else begin
        batch_r <= cfg_pwdata[4:0];
      end
    end
  end

  // Vector state collected while elements are loaded.
  state_t                  state_r, state_nxt;
  logic [LEN_W-1:0]        count_r;
  logic signed [15:0]      max_r;
  logic                    vcmd_r;
  logic [COL_W-1:0]        vcol_r;
  logic                    vbad_r;
  logic [IDX_W-1:0]        j_r, j_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic signed [32:0]      prod_r, prod_nxt;
  logic signed [DOT_W-1:0] diff_r, diff_nxt;
  logic signed [48:0]      plo_r, plo_nxt, phi_r, phi_nxt;
  logic signed [56:0]      full_r, full_nxt;
  logic [OUT_W-1:0]        oval_r, oval_nxt;
  logic                    olast_r, olast_nxt, oerr_r, oerr_nxt, ovalid_r, ovalid_nxt;

  logic                    in_acc;
  logic [COL_W-1:0]        in_col;
  logic signed [15:0]      in_val;
  logic                    clear;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign in_col    = in_tdata[3:0];
  assign in_val    = in_tdata[19:4];

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      count_r <= '0;
      max_r   <= 16'sh8000;
      vcmd_r  <= CMD_FWD;
      vcol_r  <= '0;
      vbad_r  <= 1'b0;
    end else if (in_acc) begin
      if (count_r == '0) begin
        vcmd_r <= in_tuser;
        vcol_r <= in_col;
      end else if (in_tuser != vcmd_r || in_col != vcol_r) begin
        vbad_r <= 1'b1;
      end
      if (in_val > max_r) begin
        max_r <= in_val;
      end
      if (count_r != 7'd127) begin
        count_r <= count_r + 7'd1;
      end
    end
  end

  // Memories: raw elements, exp values and the per-column probability cache.
  logic [15:0]      elem_rd;
  logic [E_W-1:0]   e_rd;
  logic [15:0]      cache_rd;
  logic             e_we, cache_we;
  logic [15:0]      p_sat;
  logic             elem_we;

  assign elem_we = in_acc && (count_r < LEN_W'(MAX_LEN));

  smfb_ram #(.AW(IDX_W), .DW(16)) u_elem (
    .clk(clk), .we(elem_we), .waddr(count_r[IDX_W-1:0]), .wdata(in_tdata[19:4]),
    .raddr(j_r), .rdata(elem_rd)
  );

  logic         exp_start, exp_done;
  logic [E_W-1:0] exp_e;

  smfb_ram #(.AW(IDX_W), .DW(E_W)) u_e (
    .clk(clk), .we(e_we), .waddr(j_r), .wdata(exp_e),
    .raddr(j_r), .rdata(e_rd)
  );

  smfb_ram #(.AW(CACHE_AW), .DW(16)) u_cache (
    .clk(clk), .we(cache_we), .waddr({vcol_r, j_r}), .wdata(p_sat),
    .raddr({vcol_r, j_r}), .rdata(cache_rd)
  );

  // Exp unit for the forward pass: t = max - x, always non-negative.
  logic signed [16:0] t_full;
  assign t_full = {max_r[15], max_r} - {elem_rd[15], elem_rd};

  smfb_exp u_exp (
    .clk(clk), .rst_n(rst_n), .start(exp_start), .t(t_full[15:0]),
    .done(exp_done), .e(exp_e)
  );

  // Serial divider for the normalization.
  logic             div_start, div_done;
  logic [Q_W-1:0]   div_q;
  logic [NUM_W-1:0] div_num;

  assign div_num = {e_rd, 16'd0} + {12'd0, sum_r[SUM_W-1:1]};
  assign p_sat   = (div_q > Q_W'(65535)) ? 16'hFFFF : div_q[15:0];

  smfb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(sum_r),
    .done(div_done), .quo(div_q)
  );

  // Vector check at the last element.
  logic             bad;
  logic [IDX_W-1:0] j_last;
  assign bad = vbad_r || (vlen_r == '0) || (vlen_r > LEN_W'(MAX_LEN)) ||
               (count_r != vlen_r) || ({1'b0, vcol_r} >= batch_r);
  assign j_last = count_r[IDX_W-1:0] - IDX_W'(1);

  // Backward rounding: magnitude round half up at bit 32, then saturate.
  logic [56:0] mag;
  logic [24:0] rmag;
  logic [16:0] dx;
  assign mag  = full_r[56] ? 57'(-full_r) : 57'(full_r);
  assign rmag = 25'((mag + 57'h0_8000_0000) >> 32);
  always_comb begin
    if (!full_r[56]) begin
      dx = (rmag > 25'd32767) ? 17'd32767 : 17'(rmag);
    end else begin
      dx = (rmag > 25'd32768) ? 17'h18000 : 17'(-$signed({1'b0, rmag[15:0]}));
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, oval_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

  // Sequencer: walks the element index through each pass.
  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    sum_nxt    = sum_r;
    dot_nxt    = dot_r;
    prod_nxt   = prod_r;
    diff_nxt   = diff_r;
    plo_nxt    = plo_r;
    phi_nxt    = phi_r;
    full_nxt   = full_r;
    oval_nxt   = oval_r;
    olast_nxt  = olast_r;
    oerr_nxt   = oerr_r;
    ovalid_nxt = ovalid_r;
    exp_start  = 1'b0;
    div_start  = 1'b0;
    e_we       = 1'b0;
    cache_we   = 1'b0;
    clear      = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_acc && in_tlast) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        j_nxt   = '0;
        sum_nxt = '0;
        dot_nxt = '0;
        if (bad) begin
          oval_nxt   = '0;
          olast_nxt  = 1'b1;
          oerr_nxt   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_EMIT;
        end else if (vcmd_r == CMD_FWD) begin
          state_nxt = S_F1_RD;
        end else begin
          state_nxt = S_D1_RD;
        end
      end
      S_F1_RD:  state_nxt = S_F1_EXP;
      S_F1_EXP: begin
        exp_start = 1'b1;
        state_nxt = S_F1_WAIT;
      end
      S_F1_WAIT: begin
        if (exp_done) begin
          e_we    = 1'b1;
          sum_nxt = sum_r + SUM_W'(exp_e);
          if (j_r == j_last) begin
            j_nxt     = '0;
            state_nxt = S_F2_RD;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = S_F1_RD;
          end
        end
      end
      S_F2_RD:  state_nxt = S_F2_DIV;
      S_F2_DIV: begin
        div_start = 1'b1;
        state_nxt = S_F2_WAIT;
      end
      S_F2_WAIT: begin
        if (div_done) begin
          cache_we   = 1'b1;
          oval_nxt   = {1'b0, p_sat};
          olast_nxt  = (j_r == j_last);
          oerr_nxt   = 1'b0;
          ovalid_nxt = 1'b1;
          state_nxt  = S_EMIT;
        end
      end
      S_D1_RD:  state_nxt = S_D1_MUL;
      S_D1_MUL: begin
        prod_nxt  = $signed(elem_rd) * $signed({1'b0, cache_rd});
        state_nxt = S_D1_ACC;
      end
      S_D1_ACC: begin
        dot_nxt = dot_r + DOT_W'(prod_r);
        if (j_r == j_last) begin
          j_nxt     = '0;
          state_nxt = S_D2_RD;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_D1_RD;
        end
      end
      S_D2_RD:   state_nxt = S_D2_DIFF;
      S_D2_DIFF: begin
        diff_nxt  = (DOT_W'($signed(elem_rd)) <<< 16) - dot_r;
        state_nxt = S_D2_MLO;
      end
      S_D2_MLO: begin
        plo_nxt   = diff_r * $signed({1'b0, cache_rd[7:0]});
        state_nxt = S_D2_MHI;
      end
      S_D2_MHI: begin
        phi_nxt   = diff_r * $signed({1'b0, cache_rd[15:8]});
        state_nxt = S_D2_SUM;
      end
      S_D2_SUM: begin
        full_nxt  = 57'(plo_r) + (57'(phi_r) <<< 8);
        state_nxt = S_D2_FIN;
      end
      S_D2_FIN: begin
        oval_nxt   = dx;
        olast_nxt  = (j_r == j_last);
        oerr_nxt   = 1'b0;
        ovalid_nxt = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            clear     = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = (vcmd_r == CMD_FWD) ? S_F2_RD : S_D2_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      ovalid_r <= 1'b0;
      j_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      j_r      <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    dot_r   <= dot_nxt;
    prod_r  <= prod_nxt;
    diff_r  <= diff_nxt;
    plo_r   <= plo_nxt;
    phi_r   <= phi_nxt;
    full_r  <= full_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

endmodule
